// ----- rtl/assert_macros.svh -----
// assertion macros shared by the heartbeat watchdog rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is high
`define THBW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, for a property that must never hold
`define THBW_NEVER(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`endif

// ----- rtl/thbw_pkg.sv -----
// types and constants for the task heartbeat watchdog
// no dependencies
`timescale 1ns / 1ps

package thbw_pkg;

  localparam int unsigned RELOAD_W  = 12;
  localparam int unsigned DIV_W     = 9;
  localparam int unsigned CRIT_W    = 4;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned ID_W      = 4;
  localparam int unsigned ALIVE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;
  // span of the critical mask: every value of the critical count field
  localparam int unsigned CRIT_SPAN = 16;

  localparam logic [RELOAD_W-1:0] RELOAD_RST = 12'd500;
  localparam logic [DIV_W-1:0]    DIV_RST    = 9'd32;
  localparam logic [CRIT_W-1:0]   CRIT_RST   = 4'd3;
  localparam logic [DIV_W-1:0]    DIV_MIN    = 9'd1;
  localparam logic [DIV_W-1:0]    DIV_MAX    = 9'd256;

  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_CHECK = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELOAD = 2'd0,
    CFG_DIV    = 2'd1,
    CFG_CRIT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RELOAD_W-1:0] reload_value;
    logic [DIV_W-1:0]    prescale_div;
    logic [CRIT_W-1:0]   critical_count;
  } cfg_t;

  typedef struct packed {
    logic                system_reset;
    logic                refreshed;
    logic [RELOAD_W-1:0] countdown_now;
    logic [ALIVE_W-1:0]  alive_now;
  } result_t;

endpackage

// ----- rtl/thbw_cfg.sv -----
// configuration registers of the heartbeat watchdog, restored on expiry
// depends on thbw_pkg
`timescale 1ns / 1ps

module thbw_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [thbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [thbw_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              expire,
  output thbw_pkg::cfg_t                    cfg
);
  import thbw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || expire) begin
      cfg.reload_value   <= RELOAD_RST;
      cfg.prescale_div   <= DIV_RST;
      cfg.critical_count <= CRIT_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RELOAD: cfg.reload_value   <= cfg_data[RELOAD_W-1:0];
        CFG_DIV:    cfg.prescale_div   <= cfg_data[DIV_W-1:0];
        CFG_CRIT:   cfg.critical_count <= cfg_data[CRIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/thbw_engine.sv -----
// heartbeat flags, prescaler and countdown with their single-event update
// depends on thbw_pkg and assert_macros.svh
`timescale 1ns / 1ps

module thbw_engine #(
  parameter int unsigned TASKS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  thbw_pkg::op_t                op,
  input  logic [thbw_pkg::ID_W-1:0]    id,
  input  thbw_pkg::cfg_t               cfg,
  output thbw_pkg::result_t            res
);
  import thbw_pkg::*;
  `include "assert_macros.svh"

  logic [TASKS-1:0]     alive, alive_next;
  logic [TICK_W-1:0]    tick_div, tick_div_next;
  logic [RELOAD_W-1:0]  countdown, countdown_next;

  logic [CRIT_SPAN-1:0] need;
  logic [CRIT_SPAN-1:0] flags_wide;
  logic [CRIT_SPAN-1:0] flags_out;
  logic [DIV_W-1:0]     div_eff;
  logic [DIV_W-1:0]     tick_inc;
  logic                 all_alive;
  logic                 expired;
  logic                 refreshed;

  // mask of the lowest critical_count task ids
  always_comb begin
    for (int i = 0; i < CRIT_SPAN; i++) begin
      need[i] = (CRIT_W'(i) < cfg.critical_count);
    end
  end

  assign flags_wide = CRIT_SPAN'(alive);
  assign all_alive  = &(flags_wide | ~need);

  // prescaler divide clamped to one through 256
  always_comb begin
    if (cfg.prescale_div == '0) begin
      div_eff = DIV_MIN;
    end else if (cfg.prescale_div > DIV_MAX) begin
      div_eff = DIV_MAX;
    end else begin
      div_eff = cfg.prescale_div;
    end
  end

  assign tick_inc = {1'b0, tick_div} + DIV_W'(1);

  always_comb begin
    alive_next     = alive;
    tick_div_next  = tick_div;
    countdown_next = countdown;
    expired        = 1'b0;
    refreshed      = 1'b0;
    case (op)
      OP_FEED: begin
        // ids at or above the task count match no flag
        for (int i = 0; i < TASKS; i++) begin
          if (id == ID_W'(i)) alive_next[i] = 1'b1;
        end
      end
      OP_CHECK: begin
        if (all_alive) begin
          countdown_next = cfg.reload_value;
          refreshed      = 1'b1;
        end
        alive_next = '0;
      end
      OP_TICK: begin
        if (tick_inc >= div_eff) begin
          tick_div_next = '0;
          if (countdown <= RELOAD_W'(1)) begin
            expired = 1'b1;
          end else begin
            countdown_next = countdown - RELOAD_W'(1);
          end
        end else begin
          tick_div_next = tick_inc[TICK_W-1:0];
        end
        if (expired) begin
          alive_next     = '0;
          tick_div_next  = '0;
          countdown_next = RELOAD_RST;
        end
      end
      default: ;
    endcase
  end

  assign flags_out         = CRIT_SPAN'(alive_next);
  assign res.system_reset  = expired;
  assign res.refreshed     = refreshed;
  assign res.countdown_now = countdown_next;
  assign res.alive_now     = flags_out[ALIVE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      alive     <= '0;
      tick_div  <= '0;
      countdown <= RELOAD_RST;
    end else if (step) begin
      alive     <= alive_next;
      tick_div  <= tick_div_next;
      countdown <= countdown_next;
    end
  end

  `THBW_ASSERT(a_expiry_restores, clk, rst,
    step && res.system_reset |=> countdown == RELOAD_RST && alive == '0 && tick_div == '0,
    "expiry did not restore the reset state")
  `THBW_ASSERT(a_check_clears, clk, rst,
    step && op == OP_CHECK |=> alive == '0,
    "alive flags survived a check")
  `THBW_ASSERT(a_tick_step_one, clk, rst,
    step && op == OP_TICK && !res.system_reset |=>
      countdown == $past(countdown) || countdown == $past(countdown) - RELOAD_W'(1),
    "countdown moved by more than one on a tick")

endmodule

// ----- rtl/task_heartbeat_watchdog_core.sv -----
// task heartbeat watchdog: one event per transfer, one result per event
// an event passes from the input register through the engine into the result register
// throughput: one event per cycle; the input register holds one event while a result is stalled
// reset: synchronous and active high; flags and prescaler clear, countdown 500,
// configuration back to reload 500, divide 32, critical count 3; expiry does the same
// depends on thbw_pkg, thbw_cfg, thbw_engine and assert_macros.svh
`timescale 1ns / 1ps

module task_heartbeat_watchdog_core #(
  parameter int unsigned TASKS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [thbw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [thbw_pkg::CFG_DAT_W-1:0]     cfg_data,
  // event channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         operation,
  input  logic [thbw_pkg::ID_W-1:0]          task_id,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               system_reset,
  output logic                               refreshed,
  output logic [thbw_pkg::RELOAD_W-1:0]      countdown_now,
  output logic [thbw_pkg::ALIVE_W-1:0]       alive_now
);
  import thbw_pkg::*;
  `include "assert_macros.svh"

  // input register: one event waiting for the engine
  logic              in_full;
  op_t               in_op;
  logic [ID_W-1:0]   in_id;

  // handshake between the two registers
  logic              accept;
  logic              advance;

  cfg_t              cfg;
  result_t           res;

  // the event moves on when the result register is empty or being drained
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_op <= op_t'(operation);
      in_id <= task_id;
    end
  end

  // configuration registers, restored to reset values when the countdown expires
  thbw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .expire    (advance && res.system_reset),
    .cfg       (cfg)
  );

  // state update for the event in the input register
  thbw_engine #(
    .TASKS (TASKS)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .op   (in_op),
    .id   (in_id),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      system_reset  <= res.system_reset;
      refreshed     <= res.refreshed;
      countdown_now <= res.countdown_now;
      alive_now     <= res.alive_now;
    end
  end

  `THBW_ASSERT(a_result_from_event, clk, rst,
    $rose(result_valid) |-> $past(advance),
    "result appeared without an event moving on")
  `THBW_NEVER(a_no_refresh_on_expiry, clk, rst,
    result_valid && system_reset && refreshed,
    "expiry and refresh reported for one event")

endmodule
